[hdl/sorted_interval_region_classifier_assert.svh]
// ============================================================================
// Sorted interval region classifier - assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ============================================================================
`ifndef SORTED_INTERVAL_REGION_CLASSIFIER_ASSERT_SVH
`define SORTED_INTERVAL_REGION_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SIRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sirc assertion failed");
// Next-cycle implication
`define SIRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sirc assertion failed");
`else
`define SIRC_ASSERT_NOW(lbl, ante, cons)
`define SIRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/sirc_pkg.sv]
// ============================================================================
// sirc_pkg
// Shared types and codes of the sorted interval region classifier.
// ============================================================================
package sirc_pkg;

    // Faces and positions at doubled scale (1/32 mm), signed
    localparam int FACE_W = 34;
    typedef logic signed [FACE_W-1:0] face_t;

    // Item kinds
    localparam logic [1:0] MODE_CLEAR    = 2'd0;
    localparam logic [1:0] MODE_LOAD     = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    // Region codes
    localparam logic [2:0] REGION_NONE    = 3'd0;
    localparam logic [2:0] REGION_INSIDE  = 3'd1;
    localparam logic [2:0] REGION_BELOW   = 3'd2;
    localparam logic [2:0] REGION_ABOVE   = 3'd3;
    localparam logic [2:0] REGION_BETWEEN = 3'd4;
    localparam logic [2:0] REGION_OVERLAP = 3'd5;

    // Configuration register indexes
    localparam logic [7:0] CFG_UNIT_LENGTH = 8'd0;
    localparam logic [7:0] CFG_SLAB_HEIGHT = 8'd1;

    typedef struct packed {
        face_t      lo;
        face_t      hi;
        logic [7:0] id;
    } slab_t;

    // Handed from a cell to both neighbors
    typedef struct packed {
        logic  valid;
        logic  gt;      // cell's lower face is above the slab being inserted
        slab_t slab;
    } link_t;

    // Per-cycle command to every cell
    typedef struct packed {
        logic clear;
        logic insert;
        logic sample;
    } cell_ctrl_t;

    // Priority ripple along the chain, lowest face first
    typedef struct packed {
        logic       first;
        logic       below;
        logic       hit;
        logic [7:0] hit_id;
        logic       gap;
        logic [7:0] gap_lo_id;
        logic [7:0] gap_hi_id;
        logic       above;
    } carry_t;

endpackage

[hdl/sirc_cell.sv]
// ============================================================================
// sirc_cell
// One slot of the sorted slab chain: holds a slab, clears, shifts on insert,
// samples its compare flags on classify and joins the priority ripple.
// ============================================================================
module sirc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  sirc_pkg::cell_ctrl_t ctrl,
    input  sirc_pkg::slab_t     new_slab,
    input  sirc_pkg::face_t     z,
    input  sirc_pkg::link_t     left,
    input  sirc_pkg::link_t     right,
    output sirc_pkg::link_t     link,
    input  sirc_pkg::carry_t    carry_in,
    output sirc_pkg::carry_t    carry_out
);
    import sirc_pkg::*;

    logic  valid_reg, valid_next;
    slab_t slab_reg, slab_next;
    logic  f_in_reg, f_gap_reg, f_above_reg, f_below_reg;
    logic  gt;

    // Sorted order: strictly greater lower faces move up, equal ones stay
    assign gt = valid_reg && (slab_reg.lo > new_slab.lo);

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.slab  = slab_reg;

    // Insert and clear
    always_comb
    begin
        valid_next = valid_reg;
        slab_next  = slab_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (left.gt)
            begin
                valid_next = 1'b1;
                slab_next  = left.slab;
            end
            else if (gt || (!valid_reg && left.valid))
            begin
                valid_next = 1'b1;
                slab_next  = new_slab;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slab payload and classify flags
    always_ff @(posedge clk)
    begin
        slab_reg <= slab_next;
        if (ctrl.sample)
        begin
            f_in_reg    <= valid_reg && (z >= slab_reg.lo) && (z <= slab_reg.hi);
            f_gap_reg   <= valid_reg && right.valid && (z > slab_reg.hi)
                           && (z < right.slab.lo);
            f_above_reg <= valid_reg && !right.valid && (z > slab_reg.hi);
            f_below_reg <= z < slab_reg.lo;
        end
    end

    // Priority ripple: the lowest cell that matches wins
    always_comb
    begin
        carry_out.first     = 1'b0;
        carry_out.below     = carry_in.below | (carry_in.first & f_below_reg);
        carry_out.hit       = carry_in.hit | f_in_reg;
        carry_out.hit_id    = carry_in.hit ? carry_in.hit_id : slab_reg.id;
        carry_out.gap       = carry_in.gap | f_gap_reg;
        carry_out.gap_lo_id = carry_in.gap ? carry_in.gap_lo_id : slab_reg.id;
        carry_out.gap_hi_id = carry_in.gap ? carry_in.gap_hi_id : right.slab.id;
        carry_out.above     = carry_in.above | f_above_reg;
    end

endmodule

[hdl/sorted_interval_region_classifier.sv]
// ============================================================================
// sorted_interval_region_classifier
// Sorted table of detector slabs with position region lookup.
// ============================================================================
// Usage:
//   s_axis items: tuser = mode (clear, load, classify); tdata = slab_id,
//   rack_slot, position. Only a classify item gives a result item on m_axis
//   (tuser = region; tdata = hit_id, gap ids, overflow flag).
//   cfg writes unit_length (index 0) or slab_height (index 1) while the
//   block is idle; cfg_ready is always high.
// Timing:
//   One item is in work at a time; s_axis_tready is high only when idle.
//   Clear, unused mode and a load into a full table end at accept. A load
//   does the face math at accept, then one insert shift of the chain. A
//   classify has the cells compare at accept; from ST_SELECT the priority
//   ripple then loads the output register once the output is free.
// Reset: table empty, overflow flag clear, unit_length 711, slab_height 0.
// Stall: a waiting result holds its value; further items are taken, and a
//   classify that finishes behind it holds until the receiver takes it.
// ============================================================================
`include "sorted_interval_region_classifier_assert.svh"

module sorted_interval_region_classifier
#(
    parameter int MAX_SLABS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // slab_id[7:0], rack_slot[15:8], position[47:16]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // hit_id[7:0], gap_lower_id[15:8],
                                       // gap_upper_id[23:16], overflow[24], zero[31:25]
    output logic [2:0]  m_axis_tuser,  // region[2:0]
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sirc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_INSERT, ST_SELECT} state_t;

    state_t      state_reg, state_next;
    logic [15:0] unit_length_reg, slab_height_reg;
    logic        dropped_reg, dropped_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  region_reg, region_next;
    logic [7:0]  hit_id_reg, hit_id_next;
    logic [7:0]  gap_lo_reg, gap_lo_next;
    logic [7:0]  gap_hi_reg, gap_hi_next;
    logic        ovf_reg, ovf_next;
    slab_t       new_slab_reg, new_slab_next;

    logic        accept;
    logic [1:0]  mode;
    logic [7:0]  in_id, in_slot;
    logic [31:0] in_pos;
    logic [23:0] prod;
    face_t       centre2, height, z;
    logic        full;
    cell_ctrl_t  ctrl;
    logic        out_free;

    link_t       links [MAX_SLABS];
    carry_t      carries [MAX_SLABS+1];
    link_t       edge_left, edge_right;
    logic [MAX_SLABS-1:0] valid_vec;
    carry_t      fin;

    assign mode    = s_axis_tuser;
    assign in_id   = s_axis_tdata[7:0];
    assign in_slot = s_axis_tdata[15:8];
    assign in_pos  = s_axis_tdata[47:16];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign full          = links[MAX_SLABS-1].valid;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Faces at doubled scale; position doubled and sign extended
    assign prod    = in_slot * unit_length_reg;
    assign centre2 = face_t'({prod, 1'b0});
    assign height  = face_t'(slab_height_reg);
    assign z       = face_t'({in_pos[31], in_pos[31], in_pos, 1'b0});

    assign new_slab_next.lo = centre2 - height;
    assign new_slab_next.hi = centre2 + height;
    assign new_slab_next.id = in_id;

    // Cell commands
    assign ctrl.clear  = accept && (mode == MODE_CLEAR);
    assign ctrl.insert = (state_reg == ST_INSERT);
    assign ctrl.sample = accept && (mode == MODE_CLASSIFY);

    // Chain boundaries
    assign edge_left.valid  = 1'b1;
    assign edge_left.gt     = 1'b0;
    assign edge_left.slab   = '0;
    assign edge_right       = '0;
    assign carries[0]       = '{first: 1'b1, default: '0};

    // Row of cells, lowest face at index 0
    for (genvar i = 0; i < MAX_SLABS; i++)
    begin : g_cell
        sirc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_slab  (new_slab_reg),
            .z         (z),
            .left      ((i == 0) ? edge_left : links[(i == 0) ? 0 : i-1]),
            .right     ((i == MAX_SLABS-1) ? edge_right
                                           : links[(i == MAX_SLABS-1) ? i : i+1]),
            .link      (links[i]),
            .carry_in  (carries[i]),
            .carry_out (carries[i+1])
        );
        assign valid_vec[i] = links[i].valid;
    end

    assign fin = carries[MAX_SLABS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_length_reg <= 16'd711;
            slab_height_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_UNIT_LENGTH: unit_length_reg <= cfg_data;
                CFG_SLAB_HEIGHT: slab_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        region_next    = region_reg;
        hit_id_next    = hit_id_reg;
        gap_lo_next    = gap_lo_reg;
        gap_hi_next    = gap_hi_reg;
        ovf_next       = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            if (full)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_INSERT;
                            end
                        end
                        MODE_CLASSIFY: state_next = ST_SELECT;
                        default:       ;
                    endcase
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_SELECT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    hit_id_next    = 8'd0;
                    gap_lo_next    = 8'd0;
                    gap_hi_next    = 8'd0;
                    ovf_next       = dropped_reg;
                    if (!links[0].valid)
                    begin
                        region_next = REGION_NONE;
                    end
                    else if (fin.hit)
                    begin
                        region_next = REGION_INSIDE;
                        hit_id_next = fin.hit_id;
                    end
                    else if (fin.below)
                    begin
                        region_next = REGION_BELOW;
                    end
                    else if (fin.above)
                    begin
                        region_next = REGION_ABOVE;
                    end
                    else if (fin.gap)
                    begin
                        region_next = REGION_BETWEEN;
                        gap_lo_next = fin.gap_lo_id;
                        gap_hi_next = fin.gap_hi_id;
                    end
                    else
                    begin
                        region_next = REGION_OVERLAP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            region_reg    <= REGION_NONE;
            hit_id_reg    <= 8'd0;
            gap_lo_reg    <= 8'd0;
            gap_hi_reg    <= 8'd0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            region_reg    <= region_next;
            hit_id_reg    <= hit_id_next;
            gap_lo_reg    <= gap_lo_next;
            gap_hi_reg    <= gap_hi_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Slab being loaded, held for the insert cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_slab_reg <= new_slab_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = region_reg;
    assign m_axis_tdata  = {7'd0, ovf_reg, gap_hi_reg, gap_lo_reg, hit_id_reg};

    // Checks
    `SIRC_ASSERT_NOW(a_valid_packed, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
    `SIRC_ASSERT_NEXT(a_full_drop, accept && (mode == MODE_LOAD) && full, dropped_reg)
    `SIRC_ASSERT_NEXT(a_clear_empties, ctrl.clear, valid_vec == '0)
    `SIRC_ASSERT_NEXT(a_select_holds, (state_reg == ST_SELECT) && !out_free,
                      (state_reg == ST_SELECT) && $stable(valid_vec))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region classifier testbench
// Streams clear, load, classify and unused-mode items into the slab table.
// Each result is checked against a local model of the sorted table or, for
// directed rows, a fixed expectation. Register settings change between
// phases, and both stream sides stall at random.
module tb;
    import sirc_pkg::*;

    localparam int          MAX_SLABS       = 16;
    localparam int          ITEM_TARGET     = 1100;
    localparam int          IDLE_PCT        = 18;
    localparam int          SETTLE_CYCLES   = 4;     // block latency plus margin
    localparam int          HOLD_CYCLES     = 80;    // long receiver stall
    localparam int          QUIET_LIMIT     = 2000;  // cycles with no handshake
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;
    localparam logic [7:0]  CFG_FIRST_SPARE = 8'd2;

    // One classify result
    typedef struct packed {
        logic [2:0] region;
        logic [7:0] hit_id;
        logic [7:0] gap_lo;
        logic [7:0] gap_hi;
        logic       ovf;
    } region_rpt_t;

    // One row of the directed table
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  id;
        logic [7:0]  slot;
        logic [31:0] pos;
        logic        typed;
        region_rpt_t want;
    } dir_row_t;

    localparam region_rpt_t NO_RPT = '0;

    // Reset settings: unit 711, height 0, so a slab at slot s sits at 711*s
    localparam dir_row_t DIRECTED [24] = '{
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd0,          1'b1, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'h7FFF_FFFF,  1'b1, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'h8000_0000,  1'b1, NO_RPT},
        '{MODE_LOAD,     8'h11, 8'd10, 32'd0,          1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7110,       1'b1,
            '{REGION_INSIDE, 8'h11, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7109,       1'b1,
            '{REGION_BELOW, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7111,       1'b1,
            '{REGION_ABOVE, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'h8000_0000,  1'b1,
            '{REGION_BELOW, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'h7FFF_FFFF,  1'b1,
            '{REGION_ABOVE, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{MODE_LOAD,     8'h22, 8'd20, 32'd0,          1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd10000,      1'b1,
            '{REGION_BETWEEN, 8'h00, 8'h11, 8'h22, 1'b0}},
        // equal lower face: new slab goes behind the existing one
        '{MODE_LOAD,     8'h33, 8'd10, 32'd0,          1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7110,       1'b1,
            '{REGION_INSIDE, 8'h11, 8'h00, 8'h00, 1'b0}},
        '{MODE_LOAD,     8'hFF, 8'hFF, 32'd0,          1'b0, NO_RPT},
        '{MODE_LOAD,     8'h00, 8'h00, 32'd0,          1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd181305,     1'b1,
            '{REGION_INSIDE, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd0,          1'b1,
            '{REGION_INSIDE, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd100000,     1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7000,       1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'hFFFF_FFFF,  1'b1,
            '{REGION_BELOW, 8'h00, 8'h00, 8'h00, 1'b0}},
        // unused mode: must be ignored
        '{MODE_UNUSED,   8'hFF, 8'hFF, 32'hFFFF_FFFF,  1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd10000,      1'b0, NO_RPT},
        '{MODE_CLEAR,    8'hA5, 8'h5A, 32'h1234_5678,  1'b0, NO_RPT},
        '{MODE_CLASSIFY, 8'h00, 8'h00, 32'd7110,       1'b1, NO_RPT}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // Local copy of the slab table and its settings
    face_t       lo_tab [MAX_SLABS];
    face_t       hi_tab [MAX_SLABS];
    logic [7:0]  id_tab [MAX_SLABS];
    int          n_slabs  = 0;
    logic        dropped  = 1'b0;
    logic [15:0] unit_len = 16'd711;
    logic [15:0] height   = 16'd0;

    region_rpt_t reports_due [$];
    int          n_errors = 0;
    int          n_items  = 0;
    int          idle_pct = IDLE_PCT;
    bit          stall_req = 1'b0;

    sorted_interval_region_classifier #(.MAX_SLABS(MAX_SLABS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // slab_id[7:0], rack_slot[15:8], position[47:16]
        .s_axis_tuser  (s_axis_tuser),   // mode[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // hit_id, gap_lower_id, gap_upper_id, overflow
        .m_axis_tuser  (m_axis_tuser),   // region[2:0]
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Insert a slab after all slabs with a lower face at or below its own
    function automatic void insert_slab(input logic [7:0] id, input logic [7:0] slot);
        face_t centre;
        face_t lo;
        face_t hi;
        int    at;
        if (n_slabs >= MAX_SLABS)
        begin
            dropped = 1'b1;
            return;
        end
        centre = face_t'(2 * longint'(slot) * longint'(unit_len));
        lo     = centre - face_t'(longint'(height));
        hi     = centre + face_t'(longint'(height));
        at = 0;
        while (at < n_slabs && lo_tab[at] <= lo)
            at++;
        for (int k = n_slabs; k > at; k--)
        begin
            lo_tab[k] = lo_tab[k-1];
            hi_tab[k] = hi_tab[k-1];
            id_tab[k] = id_tab[k-1];
        end
        lo_tab[at] = lo;
        hi_tab[at] = hi;
        id_tab[at] = id;
        n_slabs++;
    endfunction

    // Region of a position against the sorted table, at doubled scale
    function automatic region_rpt_t locate_region(input logic signed [31:0] pos);
        region_rpt_t r;
        face_t       z;
        r        = '0;
        r.region = REGION_NONE;
        r.ovf    = dropped;
        z        = {pos[31], pos, 1'b0};
        if (n_slabs == 0)
            return r;
        for (int i = 0; i < n_slabs; i++)
        begin
            if (z >= lo_tab[i] && z <= hi_tab[i])
            begin
                r.region = REGION_INSIDE;
                r.hit_id = id_tab[i];
                return r;
            end
        end
        if (z < lo_tab[0])
        begin
            r.region = REGION_BELOW;
            return r;
        end
        if (z > hi_tab[n_slabs-1])
        begin
            r.region = REGION_ABOVE;
            return r;
        end
        for (int i = 0; i + 1 < n_slabs; i++)
        begin
            if (z > hi_tab[i] && z < lo_tab[i+1])
            begin
                r.region = REGION_BETWEEN;
                r.gap_lo = id_tab[i];
                r.gap_hi = id_tab[i+1];
                return r;
            end
        end
        r.region = REGION_OVERLAP;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("tb: mismatch %0d at %0t: %s", n_errors, $realtime, msg);
    endtask

    // Offer one item, wait for acceptance, then update the model.
    // tvalid is left high; the next offer or drain() sets it.
    task automatic offer(input logic [1:0] mode, input logic [7:0] id,
                         input logic [7:0] slot, input logic signed [31:0] pos,
                         input logic typed, input region_rpt_t want);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, slot, id};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (mode != MODE_UNUSED)
            n_items++;
        case (mode)
            MODE_CLEAR:    n_slabs = 0;
            MODE_LOAD:     insert_slab(id, slot);
            MODE_CLASSIFY: reports_due.insert(reports_due.size(),
                                              typed ? want : locate_region(pos));
            default: ;
        endcase
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; cfg_valid stays high until the caller lowers it
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_UNIT_LENGTH: unit_len = value;
            CFG_SLAB_HEIGHT: height   = value;
            default: ;
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin
        region_rpt_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reports_due.size() == 0)
                report_mismatch($sformatf("result with none due, region %0d", m_axis_tuser));
            else
            begin
                want = reports_due.pop_front();
                if (m_axis_tuser != want.region)
                    report_mismatch($sformatf("region %0d, want %0d",
                                              m_axis_tuser, want.region));
                if (m_axis_tdata[7:0] != want.hit_id)
                    report_mismatch($sformatf("hit_id %h, want %h",
                                              m_axis_tdata[7:0], want.hit_id));
                if (m_axis_tdata[15:8] != want.gap_lo)
                    report_mismatch($sformatf("gap_lower_id %h, want %h",
                                              m_axis_tdata[15:8], want.gap_lo));
                if (m_axis_tdata[23:16] != want.gap_hi)
                    report_mismatch($sformatf("gap_upper_id %h, want %h",
                                              m_axis_tdata[23:16], want.gap_hi));
                if (m_axis_tdata[24] != want.ovf)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              m_axis_tdata[24], want.ovf));
                if (m_axis_tdata[31:25] != '0)
                    report_mismatch($sformatf("pad bits %h", m_axis_tdata[31:25]));
            end
        end
    end

    // Receiver: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [15:0]        ul;
        logic [15:0]        ht;
        logic [7:0]         base;
        logic [7:0]         slot;
        logic signed [31:0] pos;
        face_t              f;
        int                 n_load;
        int                 n_class;
        int                 pick;
        int                 k;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_CLEAR;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_UNIT_LENGTH;
        cfg_data      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        for (int r = 0; r < $size(DIRECTED); r++)
            offer(DIRECTED[r].mode, DIRECTED[r].id, DIRECTED[r].slot, DIRECTED[r].pos,
                  DIRECTED[r].typed, DIRECTED[r].want);

        // Random phases: settings, optional clear, loads, then classify burst
        for (int phase = 0; n_items < ITEM_TARGET; phase++)
        begin
            drain();
            case (phase % 5)
                0:       ul = 16'd1;
                1:       ul = 16'hFFFF;
                2:       ul = 16'd0;      // every centre at zero
                3:       ul = 16'd711;
                default: ul = 16'($urandom_range(1, 65535));
            endcase
            case (phase % 4)
                0:       ht = 16'd0;
                1:       ht = 16'hFFFF;
                2:       ht = 16'($urandom_range(0, 3000));
                default: ht = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_UNIT_LENGTH, ul);
            write_reg(CFG_SLAB_HEIGHT, ht);
            // write to an index with no register behind it
            if (phase % 3 == 1)
                write_reg(8'($urandom_range(CFG_FIRST_SPARE, 255)), 16'($urandom));
            cfg_valid <= 1'b0;

            idle_pct = (phase >= 6 && phase < 10) ? 0 : IDLE_PCT;

            // Keep old slabs now and then so mixed settings share the table
            if (phase % 3 != 2)
                offer(MODE_CLEAR, 8'($urandom), 8'($urandom), 32'($urandom), 1'b0, NO_RPT);

            // Large load bursts only late, since the overflow flag never clears
            if (phase >= 12 && phase % 4 == 0)
                n_load = $urandom_range(14, 20);
            else
                n_load = $urandom_range(1, 9);
            base = 8'($urandom_range(0, 249));
            for (int i = 0; i < n_load; i++)
            begin
                slot = $urandom_range(1) ? 8'($urandom) : base + 8'($urandom_range(6));
                offer(MODE_LOAD, 8'($urandom), slot, 32'($urandom), 1'b0, NO_RPT);
            end

            if (phase == 4)
                stall_req = 1'b1;

            n_class = $urandom_range(15, 35);
            for (int i = 0; i < n_class; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    offer(MODE_UNUSED, 8'($urandom), 8'($urandom), 32'($urandom),
                          1'b0, NO_RPT);
                else if (pick < 9)
                    offer(2'($urandom), 8'($urandom), 8'($urandom), 32'($urandom),
                          1'b0, NO_RPT);
                else
                begin
                    if (pick < 70 && n_slabs > 0)
                    begin
                        // on or next to a face
                        k   = $urandom_range(n_slabs - 1);
                        f   = $urandom_range(1) ? lo_tab[k] : hi_tab[k];
                        pos = f[32:1] + (int'($urandom_range(4)) - 2);
                    end
                    else if (pick < 80)
                    begin
                        case ($urandom_range(3))
                            0:       pos = 32'h8000_0000;
                            1:       pos = 32'h7FFF_FFFF;
                            2:       pos = 32'd0;
                            default: pos = 32'hFFFF_FFFF;
                        endcase
                    end
                    else
                        pos = 32'($urandom);
                    offer(MODE_CLASSIFY, 8'($urandom), 8'($urandom), pos, 1'b0, NO_RPT);
                end
            end
        end

        drain();
        if (n_errors == 0 && reports_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/sirc_pkg.sv
hdl/sirc_cell.sv
hdl/sorted_interval_region_classifier.sv
tb/tb.sv
